// File: rtl/dlpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlpd_pkg
// Shared types and constants for the decimal length prefix deframer.
// ----------------------------------------------------------------------------
package dlpd_pkg;

    localparam int unsigned MAX_HEADER_CHARS = 32;
    localparam int unsigned HDR_LEN_W        = 6;
    localparam int unsigned ACC_W            = 64;
    localparam int unsigned LEN_W            = 32;

    localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 32'd1048576;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_MALFORMED  = 2'd1;
    localparam logic [1:0] ERR_OVER_LIMIT = 2'd2;

    // characters
    localparam logic [7:0] CHR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHR_TAB     = 8'h09;
    localparam logic [7:0] CHR_VTAB    = 8'h0B;
    localparam logic [7:0] CHR_FF      = 8'h0C;
    localparam logic [7:0] CHR_CR      = 8'h0D;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_PLUS    = 8'h2B;
    localparam logic [7:0] CHR_MINUS   = 8'h2D;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last_of_frame;
        logic [1:0] error_code;
    } t_result;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_VTAB) ||
               (c == CHR_FF) || (c == CHR_CR);
    endfunction

endpackage
`default_nettype wire

// File: rtl/decimal_length_prefix_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_length_prefix_deframer
// Splits a byte stream into frames of "<decimal length>\n<payload>".
//
// Input channel i_rx_valid / o_rx_ready carries one received byte per request.
// Output channel o_out_valid / i_out_ready carries one result per request:
// a payload byte (with last mark), an empty-frame marker, or an error.
// Header bytes give no result until the newline, where the header is judged.
// A result is registered and appears on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle; the parse logic sits between the input
// handshake and a single result register, and a new byte is taken whenever
// that register is empty or being drained in the same cycle.
// When the receiver stalls with a result pending, o_rx_ready drops.
// After an error the block keeps taking bytes but drops them until reset.
// Reset (synchronous, active low) returns to the header state and sets the
// frame size limit to 1048576; i_cfg_wr_en writes a new limit from i_cfg_wr_data.
// ----------------------------------------------------------------------------
module decimal_length_prefix_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic             o_last_of_frame,
    output logic [1:0]       o_error_code
);

    logic [dlpd_pkg::LEN_W-1:0] r_max_frame_size;
    logic                       accept;
    logic                       res_valid;
    logic                       can_load;
    dlpd_pkg::t_result          res;
    dlpd_pkg::t_result          out_res;

    assign o_rx_ready = can_load;
    assign accept     = i_rx_valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_size <= dlpd_pkg::MAX_FRAME_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_frame_size <= i_cfg_wr_data;
        end
    end

    dlpd_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_byte           (i_rx_byte),
        .i_max_frame_size (r_max_frame_size),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    dlpd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .i_ready    (i_out_ready),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .o_res      (out_res)
    );

    assign o_kind          = out_res.kind;
    assign o_data_byte     = out_res.data_byte;
    assign o_last_of_frame = out_res.last_of_frame;
    assign o_error_code    = out_res.error_code;

endmodule
`default_nettype wire

// File: rtl/dlpd_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlpd_parse
// Header parser and payload counter; one request per cycle, zero or one
// result per request.
// ----------------------------------------------------------------------------
module dlpd_parse (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [7:0]                  i_byte,
    input  wire logic [dlpd_pkg::LEN_W-1:0]  i_max_frame_size,
    output logic                             o_res_valid,
    output dlpd_pkg::t_result                o_res
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_HALTED  = 2'd2;

    localparam logic [1:0] SUB_SPACE  = 2'd0;
    localparam logic [1:0] SUB_SIGN   = 2'd1;
    localparam logic [1:0] SUB_DIGITS = 2'd2;

    localparam int unsigned HL_W = dlpd_pkg::HDR_LEN_W;
    localparam int unsigned AW   = dlpd_pkg::ACC_W;
    localparam int unsigned LW   = dlpd_pkg::LEN_W;

    logic [1:0]     r_phase,  n_phase;
    logic [1:0]     r_sub,    n_sub;
    logic [HL_W-1:0] r_hdr_len, n_hdr_len;
    logic           r_bad,    n_bad;
    logic           r_neg,    n_neg;
    logic [AW-1:0]  r_acc,    n_acc;
    logic           r_ovf,    n_ovf;
    logic [LW-1:0]  r_remain, n_remain;

    logic           is_digit;
    logic [3:0]     digit;
    logic [AW+3:0]  acc_next;
    logic           bad_now;
    logic           malformed;
    logic [AW-1:0]  frame_len;
    logic           over_limit;
    logic [LW-1:0]  remain_dec;

    assign is_digit = (i_byte >= dlpd_pkg::CHR_ZERO) && (i_byte <= dlpd_pkg::CHR_NINE);
    assign digit    = 4'(i_byte - dlpd_pkg::CHR_ZERO);
    // acc * 10 + digit, upper bits flag 64-bit overflow
    assign acc_next = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + (AW+4)'(digit);

    assign bad_now    = r_bad || (r_hdr_len >= HL_W'(dlpd_pkg::MAX_HEADER_CHARS));
    assign malformed  = r_bad || (r_hdr_len == '0) || (r_sub != SUB_DIGITS) || r_ovf;
    assign frame_len  = r_neg ? (AW'(0) - r_acc) : r_acc;
    assign over_limit = (frame_len[AW-1:LW] != '0) || (frame_len[LW-1:0] > i_max_frame_size);
    assign remain_dec = (r_remain != '0) ? (r_remain - LW'(1)) : r_remain;

    always_comb begin
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_hdr_len   = r_hdr_len;
        n_bad       = r_bad;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_ovf       = r_ovf;
        n_remain    = r_remain;
        o_res_valid = 1'b0;
        o_res       = '{kind: dlpd_pkg::KIND_PAYLOAD, data_byte: 8'd0,
                        last_of_frame: 1'b0, error_code: dlpd_pkg::ERR_NONE};

        if (i_accept) begin
            case (r_phase)
                PH_PAYLOAD: begin
                    n_remain                = remain_dec;
                    o_res_valid             = 1'b1;
                    o_res.data_byte         = i_byte;
                    o_res.last_of_frame     = (remain_dec == '0);
                    if (remain_dec == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (i_byte != dlpd_pkg::CHR_NEWLINE) begin
                        if (!bad_now) begin
                            n_hdr_len = r_hdr_len + HL_W'(1);
                        end
                        n_bad = bad_now;
                        if (!bad_now) begin
                            if (is_digit) begin
                                n_sub = SUB_DIGITS;
                                if (!r_ovf) begin
                                    if (acc_next[AW+3:AW] != '0) begin
                                        n_ovf = 1'b1;
                                    end else begin
                                        n_acc = acc_next[AW-1:0];
                                    end
                                end
                            end else if (r_sub == SUB_SPACE &&
                                         dlpd_pkg::is_blank(i_byte)) begin
                                n_sub = SUB_SPACE;
                            end else if (r_sub == SUB_SPACE &&
                                         (i_byte == dlpd_pkg::CHR_PLUS ||
                                          i_byte == dlpd_pkg::CHR_MINUS)) begin
                                n_neg = (i_byte == dlpd_pkg::CHR_MINUS);
                                n_sub = SUB_SIGN;
                            end else begin
                                n_bad = 1'b1;
                            end
                        end
                    end else begin
                        // newline: judge the header and start over
                        n_sub     = SUB_SPACE;
                        n_hdr_len = '0;
                        n_bad     = 1'b0;
                        n_neg     = 1'b0;
                        n_acc     = '0;
                        n_ovf     = 1'b0;
                        if (malformed) begin
                            n_phase          = PH_HALTED;
                            o_res_valid      = 1'b1;
                            o_res.kind       = dlpd_pkg::KIND_ERROR;
                            o_res.error_code = dlpd_pkg::ERR_MALFORMED;
                        end else if (over_limit) begin
                            n_phase          = PH_HALTED;
                            o_res_valid      = 1'b1;
                            o_res.kind       = dlpd_pkg::KIND_ERROR;
                            o_res.error_code = dlpd_pkg::ERR_OVER_LIMIT;
                        end else if (frame_len == '0) begin
                            o_res_valid         = 1'b1;
                            o_res.kind          = dlpd_pkg::KIND_EMPTY;
                            o_res.last_of_frame = 1'b1;
                        end else begin
                            n_remain = frame_len[LW-1:0];
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                    // halted until reset
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_sub     <= SUB_SPACE;
            r_hdr_len <= '0;
            r_bad     <= 1'b0;
            r_neg     <= 1'b0;
            r_acc     <= '0;
            r_ovf     <= 1'b0;
            r_remain  <= '0;
        end else begin
            r_phase   <= n_phase;
            r_sub     <= n_sub;
            r_hdr_len <= n_hdr_len;
            r_bad     <= n_bad;
            r_neg     <= n_neg;
            r_acc     <= n_acc;
            r_ovf     <= n_ovf;
            r_remain  <= n_remain;
        end
    end

endmodule
`default_nettype wire

// File: rtl/dlpd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlpd_out_reg
// Result register with valid/ready toward the receiver.
// ----------------------------------------------------------------------------
module dlpd_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire dlpd_pkg::t_result  i_res,
    input  wire logic               i_ready,
    output logic                    o_can_load,
    output logic                    o_valid,
    output dlpd_pkg::t_result       o_res
);

    logic              r_valid, n_valid;
    dlpd_pkg::t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_comb begin
        n_valid = r_valid;
        if (o_can_load) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire
